// File: rtl/core/u8sv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sv_pkg
// Types and constants shared by the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       is_last;
  } u8sv_req_t;

  typedef struct packed {
    logic body_done;
    logic body_valid;
  } u8sv_rsp_t;

  typedef enum logic [2:0] {
    CLS_NORMAL = 3'd0,
    CLS_E0     = 3'd1,
    CLS_ED     = 3'd2,
    CLS_F0     = 3'd3,
    CLS_F4     = 3'd4
  } u8sv_cls_t;

  typedef struct packed {
    logic [1:0] bytes_pending;
    logic       awaiting_second;
    u8sv_cls_t  second_range_class;
    logic       error_seen;
  } u8sv_state_t;

  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] LEAD2_MIN     = 8'hc2;
  localparam logic [7:0] LEAD3_E0      = 8'he0;
  localparam logic [7:0] LEAD3_ED      = 8'hed;
  localparam logic [7:0] LEAD4_F0      = 8'hf0;
  localparam logic [7:0] LEAD4_MAX     = 8'hf4;
  localparam logic [7:0] MASK_LEAD2    = 8'he0;
  localparam logic [7:0] MASK_LEAD3    = 8'hf0;
  localparam logic [7:0] MASK_LEAD4    = 8'hf8;
  localparam logic [7:0] MASK_CONT     = 8'hc0;
  localparam logic [7:0] PAT_LEAD2     = 8'hc0;
  localparam logic [7:0] PAT_LEAD3     = 8'he0;
  localparam logic [7:0] PAT_LEAD4     = 8'hf0;
  localparam logic [7:0] PAT_CONT      = 8'h80;
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hbf;
  localparam logic [7:0] AFTER_E0_MIN  = 8'ha0;
  localparam logic [7:0] AFTER_ED_MAX  = 8'h9f;
  localparam logic [7:0] AFTER_F0_MIN  = 8'h90;
  localparam logic [7:0] AFTER_F4_MAX  = 8'h8f;

endpackage
`default_nettype wire

// File: rtl/core/u8sv_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8sv_step
// Per-word decode: next validator state and the verdict for one word.
// ----------------------------------------------------------------------------
module u8sv_step import u8sv_pkg::*; (
  input  wire u8sv_state_t st,
  input  wire u8sv_req_t   req,
  output u8sv_state_t      st_next,
  output u8sv_rsp_t        rsp
);

  logic [7:0]  b;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic        ok;
  u8sv_state_t upd;

  assign b = req.data_byte;

  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    case (st.second_range_class)
      CLS_E0:  lo = AFTER_E0_MIN;
      CLS_ED:  hi = AFTER_ED_MAX;
      CLS_F0:  lo = AFTER_F0_MIN;
      CLS_F4:  hi = AFTER_F4_MAX;
      default: ;
    endcase
  end

  always_comb begin
    upd = st;
    ok  = 1'b1;
    if (req.has_byte && !st.error_seen) begin
      if (st.bytes_pending == 2'd0) begin
        if (b == BYTE_NUL) begin
          ok = 1'b0;
        end else if (b[7]) begin
          upd.awaiting_second    = 1'b1;
          upd.second_range_class = CLS_NORMAL;
          if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            ok                = (b >= LEAD2_MIN);
            upd.bytes_pending = 2'd1;
          end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            upd.bytes_pending = 2'd2;
            if (b == LEAD3_E0) begin
              upd.second_range_class = CLS_E0;
            end else if (b == LEAD3_ED) begin
              upd.second_range_class = CLS_ED;
            end
          end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            ok                = (b <= LEAD4_MAX);
            upd.bytes_pending = 2'd3;
            if (b == LEAD4_F0) begin
              upd.second_range_class = CLS_F0;
            end else if (b == LEAD4_MAX) begin
              upd.second_range_class = CLS_F4;
            end
          end else begin
            ok = 1'b0;
          end
        end
      end else begin
        if (st.awaiting_second) begin
          ok = (b >= lo) && (b <= hi);
        end else begin
          ok = ((b & MASK_CONT) == PAT_CONT);
        end
        upd.bytes_pending      = st.bytes_pending - 2'd1;
        upd.awaiting_second    = 1'b0;
        upd.second_range_class = CLS_NORMAL;
      end
      if (!ok) begin
        upd                    = '0;
        upd.second_range_class = CLS_NORMAL;
        upd.error_seen         = 1'b1;
      end
    end
  end

  always_comb begin
    rsp.body_done = req.is_last;
    if (req.is_last) begin
      rsp.body_valid         = !upd.error_seen && (upd.bytes_pending == 2'd0);
      st_next                = '0;
      st_next.second_range_class = CLS_NORMAL;
    end else begin
      rsp.body_valid = !upd.error_seen;
      st_next        = upd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/utf8_stream_validator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// Strict UTF-8 checker, one body byte per word, sticky error per body.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register, then loads into the
//   result register when that register is free or being read.
// Throughput: one word per cycle while rsp_ready stays high; the decode
//   state updates as a word moves from the input to the result register.
// Reset: rst clears both register valids and the decode state.
module utf8_stream_validator_top import u8sv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire u8sv_req_t req_data,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output u8sv_rsp_t      rsp_data
);

  u8sv_req_t   req_q;
  logic        req_q_valid;
  u8sv_state_t st;
  u8sv_state_t st_next;
  u8sv_rsp_t   rsp_next;
  logic        rsp_load;

  assign rsp_load  = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || rsp_load;

  u8sv_step u_step (
    .st      (st),
    .req     (req_q),
    .st_next (st_next),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (rsp_load) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

  a_clear_at_end: assert property (@(posedge clk) disable iff (rst)
    rsp_load && req_q.is_last |=> (st == '0))
    else $error("state not cleared after final word");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (req_q_valid && rsp_valid))
    else $error("request stalled with free space");

  a_running_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.body_done |-> (rsp_data.body_valid == !st.error_seen))
    else $error("running verdict disagrees with error flag");

  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    st.awaiting_second |-> (st.bytes_pending != 2'd0) && !st.error_seen)
    else $error("second byte expected with nothing pending");

endmodule
`default_nettype wire

// File: sim/utf8_stream_validator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_top_tb
// Self-checking bench for the strict UTF-8 stream validator.
// A short directed part covers the edge bytes, lead and second-byte
// rejects, empty and truncated bodies, and bytes after an error. After it
// come random bodies of mostly well-formed characters, some with corrupted
// or dropped bytes, some pure noise. Every accepted word goes through a
// behavioral decoder whose verdicts are compared in order with the block's
// responses, while both sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module utf8_stream_validator_top_tb import u8sv_pkg::*;;

  localparam int          N_WORDS        = 950;
  localparam int          MAX_REPORTS    = 10;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          HOLD_START     = 150;
  localparam int          HOLD_SPAN      = 80;

  class utf8_verdict_tracker;
    logic [1:0]  cont_left;
    logic        second_next;
    u8sv_cls_t   second_cls;
    logic        err_flag;
    u8sv_rsp_t   verdict_q[$];
    int unsigned failures;
    int unsigned checked;

    function new();
      clear_body();
      failures = 0;
      checked  = 0;
    endfunction

    function void clear_body();
      cont_left   = 2'd0;
      second_next = 1'b0;
      second_cls  = CLS_NORMAL;
      err_flag    = 1'b0;
    endfunction

    function void flag_bad();
      err_flag    = 1'b1;
      cont_left   = 2'd0;
      second_next = 1'b0;
      second_cls  = CLS_NORMAL;
    endfunction

    function void take_lead(logic [7:0] b);
      logic [1:0] need;
      u8sv_cls_t  cls;
      need = 2'd0;
      cls  = CLS_NORMAL;
      if (b == BYTE_NUL) begin
        flag_bad();
        return;
      end
      if (!b[7]) return;
      if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        if (b < LEAD2_MIN) begin
          flag_bad();
          return;
        end
        need = 2'd1;
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        need = 2'd2;
        if (b == LEAD3_E0) cls = CLS_E0;
        else if (b == LEAD3_ED) cls = CLS_ED;
      end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
        if (b > LEAD4_MAX) begin
          flag_bad();
          return;
        end
        need = 2'd3;
        if (b == LEAD4_F0) cls = CLS_F0;
        else if (b == LEAD4_MAX) cls = CLS_F4;
      end else begin
        flag_bad();
        return;
      end
      cont_left   = need;
      second_next = 1'b1;
      second_cls  = cls;
    endfunction

    function bit second_in_range(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_MIN;
      hi = CONT_MAX;
      case (second_cls)
        CLS_E0: lo = AFTER_E0_MIN;
        CLS_ED: hi = AFTER_ED_MAX;
        CLS_F0: lo = AFTER_F0_MIN;
        CLS_F4: hi = AFTER_F4_MAX;
        default: ;
      endcase
      return (b >= lo) && (b <= hi);
    endfunction

    function void take_word(u8sv_req_t w);
      u8sv_rsp_t want;
      bit        ok;
      if (w.has_byte && !err_flag) begin
        if (cont_left == 2'd0) begin
          take_lead(w.data_byte);
        end else begin
          if (second_next) ok = second_in_range(w.data_byte);
          else ok = ((w.data_byte & MASK_CONT) == PAT_CONT);
          if (!ok) begin
            flag_bad();
          end else begin
            cont_left   = cont_left - 2'd1;
            second_next = 1'b0;
            second_cls  = CLS_NORMAL;
          end
        end
      end
      want.body_done = w.is_last;
      if (w.is_last) begin
        want.body_valid = !err_flag && (cont_left == 2'd0);
        clear_body();
      end else begin
        want.body_valid = !err_flag;
      end
      verdict_q.push_back(want);
    endfunction

    function void check_verdict(u8sv_rsp_t got);
      u8sv_rsp_t want;
      if (verdict_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("ERROR: response with none outstanding, done=%0b valid=%0b",
                   got.body_done, got.body_valid);
        return;
      end
      want = verdict_q.pop_front();
      if (got.body_done !== want.body_done || got.body_valid !== want.body_valid) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("ERROR: response %0d expected done=%0b valid=%0b, %s done=%0b valid=%0b",
                   checked, want.body_done, want.body_valid, "got",
                   got.body_done, got.body_valid);
      end
      checked++;
    endfunction
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  u8sv_req_t req_data  = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  u8sv_rsp_t rsp_data;

  utf8_verdict_tracker board;
  int                  words_sent  = 0;
  int                  burst_left  = 0;
  int                  idle_cycles = 0;
  logic [7:0]          body_bytes[$];

  utf8_stream_validator_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.take_word(req_data);
      if (rsp_valid && rsp_ready) board.check_verdict(rsp_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random ready, then one long hold-off, then shifting patterns.
  initial begin : rsp_side
    int mode;
    int span;
    int k;
    wait (rst == 1'b0);
    repeat (HOLD_START) begin
      @(posedge clk);
      rsp_ready <= ($urandom_range(0, 2) != 0);
    end
    repeat (HOLD_SPAN) begin
      @(posedge clk);
      rsp_ready <= 1'b0;
    end
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ready <= ((k % 3) != 2);
          default: rsp_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic offer(input logic has, input logic [7:0] b, input logic last);
    u8sv_req_t w;
    int        gap;
    w.has_byte  = has;
    w.data_byte = b;
    w.is_last   = last;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_data  <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic append_char();
    int         kind;
    int         pick;
    logic [7:0] lead;
    logic [7:0] second;
    kind = $urandom_range(0, 3);
    case (kind)
      0: body_bytes.push_back(8'($urandom_range(1, 127)));
      1: begin
        body_bytes.push_back(8'($urandom_range(LEAD2_MIN, 8'hdf)));
        body_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
      end
      2: begin
        pick = $urandom_range(0, 3);
        lead = (pick == 0) ? LEAD3_E0 : (pick == 1) ? LEAD3_ED :
               8'($urandom_range(LEAD3_E0, 8'hef));
        if (lead == LEAD3_E0) second = 8'($urandom_range(AFTER_E0_MIN, CONT_MAX));
        else if (lead == LEAD3_ED) second = 8'($urandom_range(CONT_MIN, AFTER_ED_MAX));
        else second = 8'($urandom_range(CONT_MIN, CONT_MAX));
        body_bytes.push_back(lead);
        body_bytes.push_back(second);
        body_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
      end
      default: begin
        pick = $urandom_range(0, 2);
        lead = (pick == 0) ? LEAD4_F0 : (pick == 1) ? LEAD4_MAX :
               8'($urandom_range(LEAD4_F0, LEAD4_MAX));
        if (lead == LEAD4_F0) second = 8'($urandom_range(AFTER_F0_MIN, CONT_MAX));
        else if (lead == LEAD4_MAX) second = 8'($urandom_range(CONT_MIN, AFTER_F4_MAX));
        else second = 8'($urandom_range(CONT_MIN, CONT_MAX));
        body_bytes.push_back(lead);
        body_bytes.push_back(second);
        body_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
        body_bytes.push_back(8'($urandom_range(CONT_MIN, CONT_MAX)));
      end
    endcase
  endtask

  task automatic random_body();
    int  n_chars;
    int  i;
    bit  noise;
    bit  sep_end;
    body_bytes = {};
    noise   = ($urandom_range(0, 9) == 0);
    sep_end = ($urandom_range(0, 3) == 0);
    n_chars = $urandom_range(0, 10);
    for (i = 0; i < n_chars; i++) begin
      if (noise) body_bytes.push_back(8'($urandom_range(0, 255)));
      else append_char();
    end
    // corrupt one byte, or cut the body short
    if (body_bytes.size() > 0 && $urandom_range(0, 7) == 0)
      body_bytes[$urandom_range(0, body_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    if (body_bytes.size() > 0 && $urandom_range(0, 9) == 0)
      void'(body_bytes.pop_back());
    for (i = 0; i < body_bytes.size(); i++) begin
      if ($urandom_range(0, 15) == 0) offer(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      offer(1'b1, body_bytes[i], (i == body_bytes.size() - 1) && !sep_end);
    end
    if (sep_end || body_bytes.size() == 0)
      offer(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : req_side
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(1'b0, 8'hff, 1'b1);
    offer(1'b1, 8'h00, 1'b1);
    offer(1'b1, 8'h7f, 1'b0);
    offer(1'b1, 8'hc2, 1'b0);
    offer(1'b1, 8'h80, 1'b0);
    offer(1'b0, 8'h5a, 1'b0);
    offer(1'b1, 8'hf4, 1'b0);
    offer(1'b1, 8'h8f, 1'b0);
    offer(1'b1, 8'hbf, 1'b0);
    offer(1'b1, 8'hbf, 1'b1);
    offer(1'b1, 8'he0, 1'b0);
    offer(1'b1, 8'h9f, 1'b0);
    offer(1'b1, 8'h41, 1'b1);
    offer(1'b1, 8'hed, 1'b0);
    offer(1'b1, 8'ha0, 1'b1);
    offer(1'b1, 8'hf0, 1'b0);
    offer(1'b1, 8'h8f, 1'b1);
    offer(1'b1, 8'hc1, 1'b1);
    offer(1'b1, 8'hf5, 1'b1);
    offer(1'b1, 8'hff, 1'b1);
    offer(1'b1, 8'h80, 1'b1);
    offer(1'b1, 8'he2, 1'b0);
    offer(1'b1, 8'h82, 1'b1);
    offer(1'b1, 8'hf4, 1'b0);
    offer(1'b1, 8'h90, 1'b1);

    while (words_sent < N_WORDS) random_body();

    req_valid <= 1'b0;
    @(posedge clk);
    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/u8sv_pkg.sv
rtl/core/u8sv_step.sv
rtl/core/utf8_stream_validator_top.sv
sim/utf8_stream_validator_top_tb.sv
